>>> hw/rtl/sorted_priority_queue_top_defines.svh
// Assertion macros used by the queue top level.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Combinational check, sampled at every rising edge outside reset.
`define SPQ_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("queue check failed");

// Check on the cycle after the trigger.
`define SPQ_ASSERT_NEXT(name, clk, rst, trig, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("queue check failed");

`endif

>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
package spq_pkg;

   localparam int SPQ_DEPTH  = 64;
   localparam int SPQ_DATA_W = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } spq_op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   typedef struct packed {
      logic                         valid;
      logic signed [SPQ_DATA_W-1:0] elem;
      logic signed [SPQ_DATA_W-1:0] prio;
   } spq_entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } spq_cmd_type;

endpackage

>>> hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
module spq_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spq_pkg::spq_cmd_type                 cmd,
   input  logic signed [spq_pkg::SPQ_DATA_W-1:0] new_elem,
   input  logic signed [spq_pkg::SPQ_DATA_W-1:0] new_prio,
   input  logic                                 prev_take,
   input  spq_pkg::spq_entry_type               prev_entry,
   input  spq_pkg::spq_entry_type               next_entry,
   output logic                                 take,
   output spq_pkg::spq_entry_type               entry
);
   import spq_pkg::*;

   logic                         valid_ff, valid_in;
   logic signed [SPQ_DATA_W-1:0] elem_ff, elem_in;
   logic signed [SPQ_DATA_W-1:0] prio_ff, prio_in;

   // An empty cell, or one of strictly lower priority, lets the new pair in here or ahead.
   assign take = !valid_ff || (new_prio > prio_ff);

   always_comb begin
      valid_in = valid_ff;
      elem_in  = elem_ff;
      prio_in  = prio_ff;
      if (cmd.insert && take) begin
         if (prev_take) begin
            valid_in = prev_entry.valid;
            elem_in  = prev_entry.elem;
            prio_in  = prev_entry.prio;
         end else begin
            valid_in = 1'b1;
            elem_in  = new_elem;
            prio_in  = new_prio;
         end
      end else if (cmd.pop) begin
         valid_in = next_entry.valid;
         elem_in  = next_entry.elem;
         prio_in  = next_entry.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      prio_ff <= prio_in;
   end

   assign entry.valid = valid_ff;
   assign entry.elem  = elem_ff;
   assign entry.prio  = prio_ff;

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Fields                                   Handshake
// req_      in         op, element_value, priority_req          req_valid / req_stall
// rsp_      out        status, popped_element, popped_priority  rsp_valid / rsp_stall
//
// One transaction is taken per cycle while req_stall is low; its response appears in the next cycle.
// Each cell compares its own priority with the incoming one and shifts locally,
// so an insert or a pop finishes in the cycle it is accepted, at any DEPTH.
// Reset empties the queue at once; there is no clearing pass.
// req_stall is high only while a response is held by rsp_stall.
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic signed [spq_pkg::SPQ_DATA_W-1:0] req_element_value,
   input  logic signed [spq_pkg::SPQ_DATA_W-1:0] req_priority_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [spq_pkg::SPQ_DATA_W-1:0] rsp_popped_element,
   output logic signed [spq_pkg::SPQ_DATA_W-1:0] rsp_popped_priority
);
   import spq_pkg::*;
   `include "sorted_priority_queue_top_defines.svh"

   localparam spq_entry_type ENTRY_NONE = '0;

   spq_entry_type entries [DEPTH];
   logic [DEPTH-1:0] takes;
   logic [DEPTH-1:0] valid_vec;
   spq_cmd_type      cmd;
   logic             req_accept;
   logic             full;
   logic             empty;

   logic                         rsp_valid_ff, rsp_valid_in;
   spq_status_type               status_ff, status_in;
   logic signed [SPQ_DATA_W-1:0] pop_elem_ff, pop_elem_in;
   logic signed [SPQ_DATA_W-1:0] pop_prio_ff, pop_prio_in;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign full       = entries[DEPTH-1].valid;
   assign empty      = !entries[0].valid;

   assign cmd.insert = req_accept && (req_op == OP_INSERT) && !full;
   assign cmd.pop    = req_accept && (req_op == OP_POP) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic          prev_take;
      spq_entry_type prev_entry;
      spq_entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_take  = 1'b0;
         assign prev_entry = ENTRY_NONE;
      end else begin : g_body
         assign prev_take  = takes[i-1];
         assign prev_entry = entries[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_entry = ENTRY_NONE;
      end else begin : g_inner
         assign next_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_elem   (req_element_value),
         .new_prio   (req_priority_req),
         .prev_take  (prev_take),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .take       (takes[i]),
         .entry      (entries[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      pop_elem_in  = pop_elem_ff;
      pop_prio_in  = pop_prio_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_DONE;
         pop_elem_in  = '0;
         pop_prio_in  = '0;
         case (req_op)
            OP_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end
            end
            OP_POP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  pop_elem_in = entries[0].elem;
                  pop_prio_in = entries[0].prio;
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      pop_elem_ff <= pop_elem_in;
      pop_prio_ff <= pop_prio_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_popped_element  = pop_elem_ff;
   assign rsp_popped_priority = pop_prio_ff;

   // Occupied cells always form an unbroken run from the front.
   `SPQ_ASSERT_ALWAYS(a_valid_contiguous, clock, reset, ((valid_vec >> 1) & ~valid_vec) == '0)
   // The front pair never has lower priority than the one behind it.
   `SPQ_ASSERT_ALWAYS(a_front_sorted, clock, reset, !entries[1].valid || (entries[0].prio >= entries[1].prio))
   // An accepted insert into a queue with room grows it by exactly one pair.
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.insert, $countones(valid_vec) == $past($countones(valid_vec)) + 1)
   // A pop accepted on an empty queue is reported as such.
   `SPQ_ASSERT_NEXT(a_pop_empty, clock, reset, req_accept && (req_op == OP_POP) && empty, rsp_status == ST_EMPTY)

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import spq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 335;

   typedef logic signed [SPQ_DATA_W-1:0] word_type;

   typedef struct {
      spq_status_type status;
      word_type       element;
      word_type       prio;
   } pop_response_type;

   // Shadow copy of the queue contents; front of the queue is index 0.
   class queue_shadow_type;
      spq_entry_type    cells[$];
      pop_response_type expected_responses[$];
      int               fail_count;
      int               checked;
      int               full_drops;
      int               empty_pops;
      int               good_pops;
      int               peak_fill;

      function void note_request(spq_op_type op, word_type element, word_type prio);
         pop_response_type resp;
         spq_entry_type    slot;
         int               pos;
         resp.status  = ST_DONE;
         resp.element = '0;
         resp.prio    = '0;
         if (op == OP_INSERT) begin
            if (cells.size() >= SPQ_DEPTH) begin
               resp.status = ST_FULL;
               full_drops++;
            end else begin
               // The new pair goes in front of the first strictly lower priority, so
               // pairs of equal priority keep their arrival order.
               pos = cells.size();
               for (int i = 0; i < cells.size(); i++) begin
                  if (prio > $signed(cells[i].prio)) begin
                     pos = i;
                     break;
                  end
               end
               slot.valid = 1'b1;
               slot.elem  = element;
               slot.prio  = prio;
               cells.insert(pos, slot);
               if (cells.size() > peak_fill) peak_fill = cells.size();
            end
         end else if (cells.size() == 0) begin
            resp.status = ST_EMPTY;
            empty_pops++;
         end else begin
            slot         = cells.pop_front();
            resp.element = slot.elem;
            resp.prio    = slot.prio;
            good_pops++;
         end
         expected_responses.push_back(resp);
      endfunction

      function void check_response(logic [1:0] status, word_type element, word_type prio);
         pop_response_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response: status %0d element %0d priority %0d",
                     $time, status, element, prio);
            fail_count++;
            return;
         end
         want = expected_responses.pop_front();
         checked++;
         if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            fail_count++;
         end
         if (element !== want.element) begin
            $display("%0t: popped element mismatch: expected %0d, actual %0d",
                     $time, want.element, element);
            fail_count++;
         end
         if (prio !== want.prio) begin
            $display("%0t: popped priority mismatch: expected %0d, actual %0d",
                     $time, want.prio, prio);
            fail_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   spq_op_type req_op = OP_INSERT;
   word_type   req_element_value = '0;
   word_type   req_priority_req = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   word_type   rsp_popped_element;
   word_type   rsp_popped_priority;

   int               idle_pct = 0;
   int               stall_pct = 0;
   int               quiet_cycles = 0;
   int               items_sent = 0;
   queue_shadow_type shadow = new();

   sorted_priority_queue_top #(
      .DEPTH(SPQ_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_element_value(req_element_value),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_popped_element(rsp_popped_element),
      .rsp_popped_priority(rsp_popped_priority)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Monitor and watchdog: both channels are sampled with their pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            shadow.check_response(rsp_status, rsp_popped_element, rsp_popped_priority);
         if (req_valid && !req_stall)
            shadow.note_request(req_op, req_element_value, req_priority_req);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(spq_op_type op, word_type element, word_type prio);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_element_value <= element;
      req_priority_req  <= prio;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Holds the sender off until every outstanding response has been checked.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (shadow.expected_responses.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic word_type random_prio();
      word_type extremes[6];
      extremes = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000,
                   32'shFFFFFFFF, 32'sh80000001, 32'sh7FFFFFFE};
      case ($urandom_range(9))
         0, 1, 2, 3: return word_type'($urandom_range(7)) - 4;
         4:          return extremes[$urandom_range(5)];
         default:    return word_type'($urandom);
      endcase
   endfunction

   task automatic fill_and_drain();
      for (int i = 0; i < SPQ_DEPTH + 3; i++)
         send_request(OP_INSERT, word_type'($urandom), random_prio());
      for (int i = 0; i < SPQ_DEPTH + 2; i++)
         send_request(OP_POP, word_type'($urandom), word_type'($urandom));
   endtask

   // Runs of insert-heavy, balanced and pop-heavy traffic push the fill level
   // between the empty and full boundaries.
   task automatic run_random(int count);
      int left;
      int run_len;
      int insert_pct;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(40, 160);
         case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         for (int i = 0; i < run_len && left > 0; i++) begin
            if ($urandom_range(99) < insert_pct)
               send_request(OP_INSERT, word_type'($urandom), random_prio());
            else
               send_request(OP_POP, word_type'($urandom), word_type'($urandom));
            left--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, extreme values, ties and mixed bit patterns.
      send_request(OP_POP, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_request(OP_INSERT, 32'sh7FFFFFFF, 32'sh00000000);
      send_request(OP_INSERT, 32'sh80000000, 32'sh7FFFFFFF);
      send_request(OP_INSERT, 32'sh00000000, 32'sh80000000);
      send_request(OP_INSERT, 32'shFFFFFFFF, 32'shFFFFFFFF);
      send_request(OP_INSERT, 32'sh00000001, 32'sh00000000);
      send_request(OP_INSERT, 32'sh00000002, 32'sh00000001);
      send_request(OP_INSERT, 32'shAAAAAAAA, 32'sh55555555);
      send_request(OP_INSERT, 32'sh55555555, 32'shAAAAAAAA);
      send_request(OP_INSERT, 32'sh00000003, 32'sh7FFFFFFF);
      send_request(OP_INSERT, 32'sh00000004, 32'sh80000000);
      for (int i = 0; i < 11; i++)
         send_request(OP_POP, 32'sh00000000, 32'sh00000000);
      wait_for_responses();

      idle_pct  = 33;
      stall_pct = 33;
      fill_and_drain();
      wait_for_responses();

      idle_pct  = 0;
      stall_pct = 0;
      run_random(PHASE_ITEMS);
      wait_for_responses();

      idle_pct  = 54;
      stall_pct = 0;
      run_random(PHASE_ITEMS);
      wait_for_responses();

      idle_pct  = 0;
      stall_pct = 54;
      run_random(PHASE_ITEMS);
      wait_for_responses();

      idle_pct  = 33;
      stall_pct = 33;
      run_random(PHASE_ITEMS);
      wait_for_responses();

      repeat (5) @(posedge clock);
      $display("summary: %0d transactions sent, %0d responses checked, %0d mismatches",
               items_sent, shadow.checked, shadow.fail_count);
      $display("summary: %0d pairs popped, %0d empty pops, %0d full drops, peak fill %0d/%0d",
               shadow.good_pops, shadow.empty_pops, shadow.full_drops, shadow.peak_fill,
               SPQ_DEPTH);
      if (shadow.fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
